// ----- src/psu_pkg.sv -----
// Shared types and constants for the PNG scanline unfilter.
`default_nettype none

package psu_pkg;

	localparam logic [2:0] FILT_NONE  = 3'd0;
	localparam logic [2:0] FILT_SUB   = 3'd1;
	localparam logic [2:0] FILT_UP    = 3'd2;
	localparam logic [2:0] FILT_AVG   = 3'd3;
	localparam logic [2:0] FILT_PAETH = 3'd4;
	localparam logic [2:0] FILT_BAD   = 3'd5;

	localparam logic REG_BYTES_PER_PIXEL = 1'b0;
	localparam logic REG_ROW_BYTES       = 1'b1;

	localparam int BPP_W = 4;
	localparam int RB_W  = 14;

	typedef struct packed {
		logic       is_data;
		logic       last;
		logic       first_row;
		logic [2:0] filt;
	} beat_info_t;

endpackage

`default_nettype wire

// ----- src/png_scanline_unfilter.sv -----
// Top level of the PNG scanline unfilter.
//
//   Group   Beat contents (lowest bit first)           Handshake
//   s_*     tdata: data_byte; tuser: frame_start         s_tvalid / s_tready
//   m_*     tdata: pixel_byte; tlast: row_end;           m_tvalid / m_tready
//           tuser: bad_filter
//   cfg_*   cfg_idx 0: bytes_per_pixel, 1: row_bytes     cfg_we
//
// One byte is taken per cycle while the output is not stalled. An accepted data
// byte passes through the input register, which is loaded together with the
// previous-row RAM read, and then the output register, which takes the
// reconstructed byte that then appears on the master side.
// The loop through the left-neighbor history and the predictor sets the rate
// of one byte per clock while the output is not stalled.
// Reset clears the row state and the histories; the previous-row RAM is not
// cleared. A stalled output holds the stage behind it, and filter type
// bytes pass through without producing a beat.
`default_nettype none

module png_scanline_unfilter #(
	parameter int MAX_ROW_BYTES   = 8192,
	parameter int MAX_PIXEL_BYTES = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] data_byte
	input  wire logic        s_tuser,  // [0] frame_start
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [7:0]  m_tdata,  // [7:0] pixel_byte
	output logic             m_tlast,
	output logic             m_tuser,  // [0] bad_filter
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [13:0] cfg_data
);

	import psu_pkg::*;

	localparam int AW = $clog2(MAX_ROW_BYTES);

	logic [BPP_W-1:0] bpp_q;
	logic [RB_W-1:0]  rb_q;

	beat_info_t info_in;
	logic [AW-1:0] idx_in;

	logic          s1_valid;
	logic [7:0]    x_s1;
	beat_info_t    info_s1;
	logic [AW-1:0] idx_s1;
	logic [7:0]    above_s1;

	logic       accept;
	logic       out_free;
	logic       s1_adv;
	logic       step;
	logic [7:0] pixel;
	logic       bad;

	logic       out_valid_q;
	logic [7:0] pix_q;
	logic       last_q;
	logic       bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q <= BPP_W'(1);
			rb_q  <= RB_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_BYTES_PER_PIXEL: bpp_q <= cfg_data[BPP_W-1:0];
				REG_ROW_BYTES:       rb_q  <= cfg_data[RB_W-1:0];
				default:             ;
			endcase
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign s1_adv   = s1_valid && (!info_s1.is_data || out_free);
	assign s_tready = !s1_valid || s1_adv;
	assign accept   = s_tvalid && s_tready;
	assign step     = s1_adv && info_s1.is_data;

	psu_row_ctrl #(
		.MAX_ROW_BYTES(MAX_ROW_BYTES)
	) u_row_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (s_tdata),
		.frame_start(s_tuser),
		.row_bytes  (rb_q),
		.info       (info_in),
		.idx        (idx_in)
	);

	psu_ram #(
		.WIDTH(8),
		.DEPTH(MAX_ROW_BYTES)
	) u_prior_row (
		.clk  (clk),
		.we   (step),
		.waddr(idx_s1),
		.wdata(pixel),
		.re   (accept),
		.raddr(idx_in),
		.rdata(above_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1    <= s_tdata;
			info_s1 <= info_in;
			idx_s1  <= idx_in;
		end
	end

	psu_recon #(
		.MAX_ROW_BYTES  (MAX_ROW_BYTES),
		.MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
	) u_recon (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.x              (x_s1),
		.info           (info_s1),
		.idx            (idx_s1),
		.above          (above_s1),
		.bytes_per_pixel(bpp_q),
		.pixel          (pixel),
		.bad            (bad)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			pix_q  <= pixel;
			last_q <= info_s1.last;
			bad_q  <= bad;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = pix_q;
	assign m_tlast  = last_q;
	assign m_tuser  = bad_q;

endmodule

`default_nettype wire

// ----- src/psu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module psu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- src/psu_row_ctrl.sv -----
// Row and column tracking: filter byte capture, column count and row end.
`default_nettype none

module psu_row_ctrl #(
	parameter int MAX_ROW_BYTES = 8192
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             accept,
	input  wire logic [7:0]                       data_byte,
	input  wire logic                             frame_start,
	input  wire logic [psu_pkg::RB_W-1:0]         row_bytes,
	output psu_pkg::beat_info_t                   info,
	output logic      [$clog2(MAX_ROW_BYTES)-1:0] idx
);

	import psu_pkg::*;

	localparam int CW = $clog2(MAX_ROW_BYTES + 1);
	localparam int AW = $clog2(MAX_ROW_BYTES);

	logic [CW-1:0] col_q;
	logic          first_q;
	logic [2:0]    filt_q;

	logic [CW-1:0] cc_eff;
	logic          first_eff;
	logic [CW-1:0] rb_eff;
	logic          last;

	always_comb begin
		cc_eff    = frame_start ? '0 : col_q;
		first_eff = frame_start | first_q;
		if (row_bytes == '0) begin
			rb_eff = CW'(1);
		end else if (32'(row_bytes) > MAX_ROW_BYTES) begin
			rb_eff = CW'(MAX_ROW_BYTES);
		end else begin
			rb_eff = CW'(row_bytes);
		end
		last = (cc_eff != '0) && (cc_eff >= rb_eff);
		idx  = AW'(cc_eff - CW'(1));

		info.is_data   = (cc_eff != '0);
		info.last      = last;
		info.first_row = first_eff;
		info.filt      = filt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			first_q <= 1'b1;
			filt_q  <= FILT_NONE;
		end else if (accept) begin
			if (cc_eff == '0) begin
				filt_q  <= (data_byte <= 8'(FILT_PAETH)) ? data_byte[2:0] : FILT_BAD;
				col_q   <= CW'(1);
				first_q <= first_eff;
			end else if (last) begin
				col_q   <= '0;
				first_q <= 1'b0;
			end else begin
				col_q   <= cc_eff + CW'(1);
				first_q <= first_eff;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/psu_recon.sv -----
// Byte reconstruction: neighbor histories, predictors and the final add.
`default_nettype none

module psu_recon #(
	parameter int MAX_ROW_BYTES   = 8192,
	parameter int MAX_PIXEL_BYTES = 8
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             step,
	input  wire logic [7:0]                       x,
	input  wire psu_pkg::beat_info_t              info,
	input  wire logic [$clog2(MAX_ROW_BYTES)-1:0] idx,
	input  wire logic [7:0]                       above,
	input  wire logic [psu_pkg::BPP_W-1:0]        bytes_per_pixel,
	output logic      [7:0]                       pixel,
	output logic                                  bad
);

	import psu_pkg::*;

	localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

	logic [7:0] left_q [MAX_PIXEL_BYTES];
	logic [7:0] ul_q   [MAX_PIXEL_BYTES];

	logic [BPP_W-1:0] bpp_eff;
	logic [PW-1:0]    sel;
	logic             has_left;
	logic [7:0]       a;
	logic [7:0]       b;
	logic [7:0]       c;
	logic [8:0]       ab_sum;
	logic [7:0]       pred;

	function automatic logic [7:0] paeth(input logic [7:0] pa_a, input logic [7:0] pa_b,
			input logic [7:0] pa_c);
		logic signed [10:0] da;
		logic signed [10:0] db;
		logic signed [10:0] dc;
		logic [9:0]         pa;
		logic [9:0]         pb;
		logic [9:0]         pc;
		da = 11'(signed'({1'b0, pa_b})) - 11'(signed'({1'b0, pa_c}));
		db = 11'(signed'({1'b0, pa_a})) - 11'(signed'({1'b0, pa_c}));
		dc = da + db;
		pa = 10'(da < 0 ? -da : da);
		pb = 10'(db < 0 ? -db : db);
		pc = 10'(dc < 0 ? -dc : dc);
		if (pa <= pb && pa <= pc) begin
			return pa_a;
		end else if (pb <= pc) begin
			return pa_b;
		end
		return pa_c;
	endfunction

	always_comb begin
		if (bytes_per_pixel == '0) begin
			bpp_eff = BPP_W'(1);
		end else if (32'(bytes_per_pixel) > MAX_PIXEL_BYTES) begin
			bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
		end else begin
			bpp_eff = bytes_per_pixel;
		end
		sel      = PW'(bpp_eff - BPP_W'(1));
		has_left = 32'(idx) >= 32'(bpp_eff);
		a        = has_left ? left_q[sel] : 8'd0;
		b        = info.first_row ? 8'd0 : above;
		c        = (has_left && !info.first_row) ? ul_q[sel] : 8'd0;
		ab_sum   = {1'b0, a} + {1'b0, b};
		bad      = 1'b0;
		case (info.filt)
			FILT_NONE:  pred = 8'd0;
			FILT_SUB:   pred = a;
			FILT_UP:    pred = b;
			FILT_AVG:   pred = ab_sum[8:1];
			FILT_PAETH: pred = paeth(a, b, c);
			default: begin
				pred = 8'd0;
				bad  = 1'b1;
			end
		endcase
		pixel = bad ? 8'd0 : x + pred;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
				left_q[k] <= 8'd0;
				ul_q[k]   <= 8'd0;
			end
		end else if (step) begin
			left_q[0] <= pixel;
			ul_q[0]   <= b;
			for (int k = 1; k < MAX_PIXEL_BYTES; k++) begin
				left_q[k] <= left_q[k-1];
				ul_q[k]   <= ul_q[k-1];
			end
		end
	end

endmodule

`default_nettype wire
